/* rtl/lqpi_pkg.sv */
package lqpi_pkg;

   localparam int BLOCK_WIDTH  = 16;
   localparam int BLOCK_HEIGHT = 16;
   localparam int WIN_W = BLOCK_WIDTH + 5;
   localparam int WIN_H = BLOCK_HEIGHT + 5;
   localparam int COL_W = $clog2(WIN_W);
   localparam int ROW_W = $clog2(WIN_H);

   // five older rows of one window column, oldest in the low byte
   localparam int STORE_ROWS = 5;
   localparam int STORE_W    = STORE_ROWS * 8;

   localparam int VR_W  = 15;   // one vertical six-tap sum of pixels
   localparam int SUM_W = 20;   // six-tap sum of vertical sums

   localparam logic signed [SUM_W-1:0] TAP_OUTER = 20'sd5;
   localparam logic signed [SUM_W-1:0] TAP_INNER = 20'sd20;
   localparam logic signed [SUM_W:0]   RND_HALF  = 21'sd16;
   localparam logic signed [SUM_W:0]   RND_CTR   = 21'sd512;
   localparam int SH_HALF = 5;
   localparam int SH_CTR  = 10;

   typedef logic [5:0][7:0] col_type;

   typedef struct packed {
      logic       vld;
      logic       emit;
      logic       last;
      logic [1:0] fx;
      logic [1:0] fy;
   } ctl_type;

   typedef struct packed {
      logic [7:0] g;
      logic [7:0] g_c1;
      logic [7:0] g_r1;
      logic [7:0] b;
      logic [7:0] b_r1;
      logic [7:0] h;
      logic [7:0] h_c1;
      logic [7:0] j;
   } smp_type;

   // quarter-sample positions, index {frac_y, frac_x}
   typedef enum logic [3:0] {
      POS_G, POS_A, POS_B, POS_C,
      POS_D, POS_E, POS_F, POS_GG,
      POS_H, POS_I, POS_J, POS_K,
      POS_N, POS_P, POS_Q, POS_R
   } pos_type;

   function automatic logic signed [SUM_W-1:0] pix_ext(input logic [7:0] p);
      return $signed({{(SUM_W-8){1'b0}}, p});
   endfunction

   function automatic logic signed [SUM_W-1:0] taps6(
      input logic signed [SUM_W-1:0] a, input logic signed [SUM_W-1:0] b,
      input logic signed [SUM_W-1:0] c, input logic signed [SUM_W-1:0] d,
      input logic signed [SUM_W-1:0] e, input logic signed [SUM_W-1:0] f);
      return a + f - TAP_OUTER * (b + e) + TAP_INNER * (c + d);
   endfunction

   function automatic logic [7:0] clip_half(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W:0] t;
      t = {s[SUM_W-1], s} + RND_HALF;
      if (t[SUM_W]) begin
         return 8'd0;
      end else if (t[SUM_W-1:SH_HALF] > 255) begin
         return 8'hFF;
      end else begin
         return t[SH_HALF+7:SH_HALF];
      end
   endfunction

   function automatic logic [7:0] clip_ctr(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W:0] t;
      t = {s[SUM_W-1], s} + RND_CTR;
      if (t[SUM_W]) begin
         return 8'd0;
      end else if (t[SUM_W-1:SH_CTR] > 255) begin
         return 8'hFF;
      end else begin
         return t[SH_CTR+7:SH_CTR];
      end
   endfunction

   function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b} + 9'd1;
      return s[8:1];
   endfunction

endpackage

/* rtl/lqpi_ram.sv */
module lqpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lqpi_col_store.sv */
module lqpi_col_store
   import lqpi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       req_valid,
   input  logic [7:0] ref_pixel,
   input  logic [1:0] frac_x,
   input  logic [1:0] frac_y,
   input  logic       window_start,
   output col_type    col,
   output ctl_type    ctl
);

   logic [ROW_W-1:0] row_ff, row_in, row_base;
   logic [COL_W-1:0] col_ff, col_in, col_base;
   logic [1:0]       hfx_ff, hfx_in, hfy_ff, hfy_in;
   ctl_type          s1_ctl_ff, s1_ctl_in;
   logic [7:0]       s1_pix_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic             accept;
   logic [STORE_W-1:0] rd_data, wr_data;

   assign accept   = req_valid & en;
   assign row_base = window_start ? '0 : row_ff;
   assign col_base = window_start ? '0 : col_ff;

   always_comb begin
      hfx_in = window_start ? frac_x : hfx_ff;
      hfy_in = window_start ? frac_y : hfy_ff;
      if (col_base == COL_W'(WIN_W - 1)) begin
         col_in = '0;
         row_in = (row_base == ROW_W'(WIN_H - 1)) ? '0 : row_base + 1'b1;
      end else begin
         col_in = col_base + 1'b1;
         row_in = row_base;
      end
      s1_ctl_in.vld  = accept;
      s1_ctl_in.emit = (row_base >= ROW_W'(5)) && (col_base >= COL_W'(5));
      s1_ctl_in.last = (row_base == ROW_W'(WIN_H - 1)) && (col_base == COL_W'(WIN_W - 1));
      s1_ctl_in.fx   = hfx_in;
      s1_ctl_in.fy   = hfy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         hfx_ff        <= '0;
         hfy_ff        <= '0;
         s1_ctl_ff.vld <= 1'b0;
      end else if (en) begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
            hfx_ff <= hfx_in;
            hfy_ff <= hfy_in;
         end
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= ref_pixel;
         s1_addr_ff <= col_base;
      end
   end

   // drop the oldest row, append the current pixel
   assign wr_data = {s1_pix_ff, rd_data[STORE_W-1:8]};

   lqpi_ram #(
      .WIDTH(STORE_W),
      .DEPTH(WIN_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (en & s1_ctl_ff.vld),
      .wr_addr(s1_addr_ff),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(col_base),
      .rd_data(rd_data)
   );

   assign col = {s1_pix_ff, rd_data};
   assign ctl = s1_ctl_ff;

endmodule

/* rtl/lqpi_filter.sv */
module lqpi_filter
   import lqpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  col_type col,
   input  ctl_type ctl_in,
   output smp_type smp,
   output ctl_type ctl_out
);

   logic signed [VR_W-1:0] vr_ff [6];
   logic [7:0]             p2_ff [6];
   logic [7:0]             p3_ff [6];
   logic signed [VR_W-1:0] vr_in;
   ctl_type                ctl2_ff, ctl3_ff;
   smp_type                smp_ff, smp_in;
   logic signed [SUM_W-1:0] vsum, hsum2, hsum3, jsum;
   logic signed [SUM_W-1:0] vr2, vr3;

   assign vsum  = taps6(pix_ext(col[0]), pix_ext(col[1]), pix_ext(col[2]),
                        pix_ext(col[3]), pix_ext(col[4]), pix_ext(col[5]));
   assign vr_in = vsum[VR_W-1:0];

   always_ff @(posedge clock) begin
      if (en && ctl_in.vld) begin
         for (int i = 0; i < 5; i++) begin
            vr_ff[i] <= vr_ff[i+1];
            p2_ff[i] <= p2_ff[i+1];
            p3_ff[i] <= p3_ff[i+1];
         end
         vr_ff[5] <= vr_in;
         p2_ff[5] <= col[2];
         p3_ff[5] <= col[3];
      end
   end

   assign hsum2 = taps6(pix_ext(p2_ff[0]), pix_ext(p2_ff[1]), pix_ext(p2_ff[2]),
                        pix_ext(p2_ff[3]), pix_ext(p2_ff[4]), pix_ext(p2_ff[5]));
   assign hsum3 = taps6(pix_ext(p3_ff[0]), pix_ext(p3_ff[1]), pix_ext(p3_ff[2]),
                        pix_ext(p3_ff[3]), pix_ext(p3_ff[4]), pix_ext(p3_ff[5]));
   assign jsum  = taps6(SUM_W'(vr_ff[0]), SUM_W'(vr_ff[1]), SUM_W'(vr_ff[2]),
                        SUM_W'(vr_ff[3]), SUM_W'(vr_ff[4]), SUM_W'(vr_ff[5]));
   assign vr2   = SUM_W'(vr_ff[2]);
   assign vr3   = SUM_W'(vr_ff[3]);

   always_comb begin
      smp_in.g    = p2_ff[2];
      smp_in.g_c1 = p2_ff[3];
      smp_in.g_r1 = p3_ff[2];
      smp_in.b    = clip_half(hsum2);
      smp_in.b_r1 = clip_half(hsum3);
      smp_in.h    = clip_half(vr2);
      smp_in.h_c1 = clip_half(vr3);
      smp_in.j    = clip_ctr(jsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.vld <= 1'b0;
         ctl3_ff.vld <= 1'b0;
      end else if (en) begin
         ctl2_ff <= ctl_in;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smp_ff <= smp_in;
      end
   end

   assign smp     = smp_ff;
   assign ctl_out = ctl3_ff;

endmodule

/* rtl/luma_quarter_pel_interpolator_unit.sv */
// Luma quarter-sample interpolator. Feed the reference window of one
// partition, (BLOCK_WIDTH+5) x (BLOCK_HEIGHT+5) pixels in raster order, one
// word per cycle; frac_x/frac_y are taken with the word that has window_start
// set, and a window without window_start reuses the held offsets. Each window
// pixel at row and column both at least 5 yields one predicted sample, in
// output raster order, BLOCK_WIDTH samples per row; block_last marks the final
// one. The block takes one word per cycle without gaps unless the output
// stalls; a sample passes the column-store, filter and output registers and is
// held in the output register while rsp_stall is high. Older window rows sit in a
// column-addressed line memory that is read and written back once per word,
// so the only stall source is a full output register.
module luma_quarter_pel_interpolator_unit
   import lqpi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ref_pixel,
   input  logic [1:0] req_frac_x,
   input  logic [1:0] req_frac_y,
   input  logic       req_window_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_pixel,
   output logic       rsp_block_last
);

   logic       en;
   col_type    col;
   ctl_type    ctl1, ctl3;
   smp_type    smp;
   logic       rsp_valid_ff;
   logic [7:0] rsp_out_pixel_ff, rsp_out_pixel_in;
   logic       rsp_block_last_ff;

   // advance the whole pipe unless a finished word waits on the output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   lqpi_col_store u_col_store (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .req_valid   (req_valid),
      .ref_pixel   (req_ref_pixel),
      .frac_x      (req_frac_x),
      .frac_y      (req_frac_y),
      .window_start(req_window_start),
      .col         (col),
      .ctl         (ctl1)
   );

   lqpi_filter u_filter (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .col    (col),
      .ctl_in (ctl1),
      .smp    (smp),
      .ctl_out(ctl3)
   );

   // pick the position, averaging two neighbors for the quarter positions
   always_comb begin
      unique case (pos_type'({ctl3.fy, ctl3.fx}))
         POS_G:  rsp_out_pixel_in = smp.g;
         POS_A:  rsp_out_pixel_in = avg2(smp.g, smp.b);
         POS_B:  rsp_out_pixel_in = smp.b;
         POS_C:  rsp_out_pixel_in = avg2(smp.g_c1, smp.b);
         POS_D:  rsp_out_pixel_in = avg2(smp.g, smp.h);
         POS_E:  rsp_out_pixel_in = avg2(smp.b, smp.h);
         POS_F:  rsp_out_pixel_in = avg2(smp.b, smp.j);
         POS_GG: rsp_out_pixel_in = avg2(smp.b, smp.h_c1);
         POS_H:  rsp_out_pixel_in = smp.h;
         POS_I:  rsp_out_pixel_in = avg2(smp.h, smp.j);
         POS_J:  rsp_out_pixel_in = smp.j;
         POS_K:  rsp_out_pixel_in = avg2(smp.j, smp.h_c1);
         POS_N:  rsp_out_pixel_in = avg2(smp.g_r1, smp.h);
         POS_P:  rsp_out_pixel_in = avg2(smp.h, smp.b_r1);
         POS_Q:  rsp_out_pixel_in = avg2(smp.j, smp.b_r1);
         POS_R:  rsp_out_pixel_in = avg2(smp.h_c1, smp.b_r1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl3.vld & ctl3.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_out_pixel_ff  <= rsp_out_pixel_in;
         rsp_block_last_ff <= ctl3.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_pixel  = rsp_out_pixel_ff;
   assign rsp_block_last = rsp_block_last_ff;

endmodule

/* rtl/lqpi_checker.sv */
module lqpi_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_ref_pixel,
   input logic [1:0] req_frac_x,
   input logic [1:0] req_frac_y,
   input logic       req_window_start,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_pixel,
   input logic       rsp_block_last
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pixel)
                                 && $stable(rsp_block_last))
   else $error("stalled result word changed");

   // input stalls only behind a blocked output word
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
   else $error("input stalled without output backpressure");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("result valid after reset");

endmodule

bind luma_quarter_pel_interpolator_unit lqpi_checker u_lqpi_checker (.*);

/* dv/luma_quarter_pel_interpolator_unit_test.sv */
`timescale 1ns / 100ps

module luma_quarter_pel_interpolator_unit_test;
   import lqpi_pkg::*;

   localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int DRAIN_CYCLES = 8;    // extra cycles waited once no sample is pending
   localparam int WIN_PIXELS = WIN_W * WIN_H;
   // words from a window start up to and including the first sample
   localparam int FIRST_OUT_WORDS = 5 * WIN_W + 6;
   // words sent in each of the first two idling phases
   localparam int PHASE_WORDS = 260;

   typedef enum logic [1:0] {PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_CHECKER} pattern_type;

   typedef struct {
      logic [7:0] pixel;
      logic       last;
   } sample_type;

   // one directed window: fill pattern, offsets, whether the first word carries
   // window_start, words sent, and a typed-in sample value where it is obvious
   typedef struct {
      pattern_type pattern;
      logic [1:0]  fx;
      logic [1:0]  fy;
      logic        start;
      int          words;
      logic        known;
      logic [7:0]  value;
   } window_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ref_pixel = '0;
   logic [1:0] req_frac_x = '0;
   logic [1:0] req_frac_y = '0;
   logic       req_window_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_pixel;
   logic       rsp_block_last;

   luma_quarter_pel_interpolator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ref_pixel    (req_ref_pixel),
      .req_frac_x       (req_frac_x),
      .req_frac_y       (req_frac_y),
      .req_window_start (req_window_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_block_last   (rsp_block_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the window and its position counters; the whole window is
   // kept, which is equivalent to the six-row store since only rows of the
   // current window are ever read
   logic [7:0] window_pixels [WIN_H][WIN_W];
   int         win_row;
   int         win_col;
   logic [1:0] held_fx;
   logic [1:0] held_fy;

   sample_type pending_samples [$];
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         idle_cycles = 0;
   int         words_sent = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // six-tap filter (1,-5,20,20,-5,1)
   function automatic int six_tap(input int a, b, c, d, e, f);
      return a - 5 * b + 20 * c + 20 * d - 5 * e + f;
   endfunction

   function automatic int full_pel(input int r, c);
      return int'(window_pixels[r][c]);
   endfunction

   // unrounded horizontal sum between columns c and c+1
   function automatic int horiz_sum(input int r, c);
      return six_tap(full_pel(r, c - 2), full_pel(r, c - 1), full_pel(r, c),
                     full_pel(r, c + 1), full_pel(r, c + 2), full_pel(r, c + 3));
   endfunction

   function automatic int vert_sum(input int r, c);
      return six_tap(full_pel(r - 2, c), full_pel(r - 1, c), full_pel(r, c),
                     full_pel(r + 1, c), full_pel(r + 2, c), full_pel(r + 3, c));
   endfunction

   function automatic int round_clip(input int v, add, sh);
      v = v + add;
      if (v < 0) begin
         return 0;
      end
      v = v >>> sh;
      return (v > 255) ? 255 : v;
   endfunction

   function automatic int half_b(input int r, c);
      return round_clip(horiz_sum(r, c), 16, 5);
   endfunction

   function automatic int half_h(input int r, c);
      return round_clip(vert_sum(r, c), 16, 5);
   endfunction

   function automatic int half_j(input int r, c);
      int s;
      s = six_tap(horiz_sum(r - 2, c), horiz_sum(r - 1, c), horiz_sum(r, c),
                  horiz_sum(r + 1, c), horiz_sum(r + 2, c), horiz_sum(r + 3, c));
      return round_clip(s, 512, 10);
   endfunction

   function automatic int mean2(input int a, b);
      return (a + b + 1) >> 1;
   endfunction

   // predicted sample with the full sample G at window (r, c)
   function automatic logic [7:0] interpolate_sample(input int r, c, input pos_type pos);
      int v;
      case (pos)
         POS_G:   v = full_pel(r, c);
         POS_A:   v = mean2(full_pel(r, c), half_b(r, c));
         POS_B:   v = half_b(r, c);
         POS_C:   v = mean2(full_pel(r, c + 1), half_b(r, c));
         POS_D:   v = mean2(full_pel(r, c), half_h(r, c));
         POS_E:   v = mean2(half_b(r, c), half_h(r, c));
         POS_F:   v = mean2(half_b(r, c), half_j(r, c));
         POS_GG:  v = mean2(half_b(r, c), half_h(r, c + 1));
         POS_H:   v = half_h(r, c);
         POS_I:   v = mean2(half_h(r, c), half_j(r, c));
         POS_J:   v = half_j(r, c);
         POS_K:   v = mean2(half_j(r, c), half_h(r, c + 1));
         POS_N:   v = mean2(full_pel(r + 1, c), half_h(r, c));
         POS_P:   v = mean2(half_h(r, c), half_b(r + 1, c));
         POS_Q:   v = mean2(half_j(r, c), half_b(r + 1, c));
         default: v = mean2(half_h(r, c + 1), half_b(r + 1, c));
      endcase
      return v[7:0];
   endfunction

   // advance the shadow window by one accepted word and queue its sample, if any
   task automatic accept_word(input logic [7:0] pix, input logic [1:0] fx, fy,
                              input logic st, input logic known, input logic [7:0] value);
      sample_type s;
      if (st) begin
         win_row = 0;
         win_col = 0;
         held_fx = fx;
         held_fy = fy;
      end
      window_pixels[win_row][win_col] = pix;
      if (win_row >= 5 && win_col >= 5) begin
         s.pixel = known ? value
                         : interpolate_sample(win_row - 3, win_col - 3, pos_type'({held_fy, held_fx}));
         s.last = (win_row == WIN_H - 1) && (win_col == WIN_W - 1);
         pending_samples.push_back(s);
      end
      win_col++;
      if (win_col >= WIN_W) begin
         win_col = 0;
         win_row++;
         if (win_row >= WIN_H) begin
            win_row = 0;
         end
      end
   endtask

   // pick the idling phase from the word count, idle at random, then hold the
   // word until the block takes it
   task automatic send_word(input logic [7:0] pix, input logic [1:0] fx, fy,
                            input logic st, input logic known, input logic [7:0] value);
      if (words_sent < PHASE_WORDS) begin
         send_idle_pct = 20;
         recv_idle_pct = 47;
      end else if (words_sent < 2 * PHASE_WORDS) begin
         send_idle_pct = 47;
         recv_idle_pct = 20;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ref_pixel <= pix;
      req_frac_x <= fx;
      req_frac_y <= fy;
      req_window_start <= st;
      do @(posedge clock); while (req_stall);
      accept_word(pix, fx, fy, st, known, value);
      words_sent++;
   endtask

   task automatic send_window(input window_row_type w);
      int r;
      int c;
      logic [7:0] pix;
      for (int i = 0; i < w.words; i++) begin
         r = i / WIN_W;
         c = i % WIN_W;
         case (w.pattern)
            PAT_ZERO:    pix = 8'd0;
            PAT_FULL:    pix = 8'd255;
            PAT_CHECKER: pix = ((r + c) % 2 == 1) ? 8'd255 : 8'd0;
            default:     pix = 8'($urandom_range(255));
         endcase
         // offsets on non-start words are ignored; drive them anyway
         if (i == 0) begin
            send_word(pix, w.fx, w.fy, w.start, w.known, w.value);
         end else begin
            send_word(pix, 2'($urandom_range(3)), 2'($urandom_range(3)), 1'b0,
                      w.known, w.value);
         end
      end
   endtask

   window_row_type directed [$];

   task automatic add_window(input pattern_type p, input int fx, fy, input logic st,
                             input int words, input logic known, input logic [7:0] value);
      window_row_type w;
      w.pattern = p;
      w.fx = 2'(fx);
      w.fy = 2'(fy);
      w.start = st;
      w.words = words;
      w.known = known;
      w.value = value;
      directed.push_back(w);
   endtask

   // output side: random stall, check each taken word against the oldest expectation
   always @(posedge clock) begin
      sample_type s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d last %0b",
                                      rsp_out_pixel, rsp_block_last));
         end else begin
            s = pending_samples.pop_front();
            if (rsp_out_pixel !== s.pixel) begin
               report_mismatch($sformatf("out_pixel %0d, want %0d", rsp_out_pixel, s.pixel));
            end
            if (rsp_block_last !== s.last) begin
               report_mismatch($sformatf("block_last %0b, want %0b", rsp_block_last, s.last));
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("luma_quarter_pel_interpolator_unit_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      window_row_type w;
      win_row = 0;
      win_col = 0;
      held_fx = '0;
      held_fy = '0;

      // no start after reset: offsets 0,0 apply even though the fields say 3,3;
      // the full window ends on block_last and wraps the counters
      add_window(PAT_RANDOM, 3, 3, 1'b0, WIN_PIXELS, 1'b0, 8'd0);
      // flat white window: every position gives 255 back
      add_window(PAT_FULL, 3, 3, 1'b1, FIRST_OUT_WORDS, 1'b1, 8'd255);
      // restart mid-window with a checkerboard fill
      add_window(PAT_CHECKER, 2, 2, 1'b1, FIRST_OUT_WORDS + 4, 1'b0, 8'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_window(directed[i]);
      end

      // random window; the idling phase follows the word count
      w.pattern = ($urandom_range(3) == 0) ? pattern_type'($urandom_range(3)) : PAT_RANDOM;
      w.fx = 2'($urandom_range(3));
      w.fy = 2'($urandom_range(3));
      w.start = ($urandom_range(4) != 0);
      w.words = $urandom_range(FIRST_OUT_WORDS, 6 * WIN_W);
      w.known = 1'b0;
      w.value = 8'd0;
      send_window(w);

      // drop valid and drain
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("luma_quarter_pel_interpolator_unit_test OK");
      end else begin
         $display("luma_quarter_pel_interpolator_unit_test NOT OK");
      end
      $finish;
   end

endmodule

/* luma_quarter_pel_interpolator_unit.f */
rtl/lqpi_pkg.sv
rtl/lqpi_ram.sv
rtl/lqpi_col_store.sv
rtl/lqpi_filter.sv
rtl/luma_quarter_pel_interpolator_unit.sv
rtl/lqpi_checker.sv
dv/luma_quarter_pel_interpolator_unit_test.sv
